### rtl/core/assert_macros.svh
// assertion macros shared by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/dq_pkg.sv
// types and constants for the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int VALUE_WIDTH        = 32;
   localparam int OP_WIDTH           = 3;
   localparam int STATUS_WIDTH       = 2;

   localparam logic [VALUE_WIDTH-1:0] EMPTY_VALUE = '1;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_ZERO  = 2'd0,
      SEL_READ  = 2'd1,
      SEL_EMPTY = 2'd2
   } result_sel_type;

   typedef struct packed {
      logic           capture;
      logic           commit;
      logic           write_en;
      logic           read_en;
      logic           advance;
      result_sel_type sel;
      status_type     status;
   } dq_cmd_type;

   typedef struct packed {
      logic is_push;
      logic is_read;
      logic empty;
      logic full;
   } dq_stat_type;

endpackage

`default_nettype wire

### rtl/core/double_ended_queue_top.sv
// top level of the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of DATA_WIDTH-bit words in a circular store of DEPTH entries.
// A request is taken at a clock edge where start is high and busy is low; busy then
// stays high while the single memory port does the write or the read, and the result
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high. A new request
// may be taken in that same result cycle, but not while busy is high. There is no way
// to hold a result off: the receiver must take it in the strobe cycle. The store needs
// no clearing after reset; only written entries are ever read.
module double_ended_queue_top #(
   parameter  int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter  int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT,
   localparam int CW         = $clog2(DEPTH + 1)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [dq_pkg::OP_WIDTH-1:0]           req_operation,
   input  wire logic signed [dq_pkg::VALUE_WIDTH-1:0] req_push_value,
   output logic                                       rsp_strobe,
   output logic signed [dq_pkg::VALUE_WIDTH-1:0]      rsp_out_value,
   output logic [dq_pkg::STATUS_WIDTH-1:0]            rsp_status,
   output logic [CW-1:0]                              rsp_entry_count
);

   dq_pkg::dq_cmd_type  cmd;
   dq_pkg::dq_stat_type stat;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   dq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_push_value  (req_push_value),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

`default_nettype wire

### rtl/core/dq_ctrl.sv
// controller state machine for the double-ended queue
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output logic                    rsp_strobe,
   input  wire dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      strobe_ff;
   logic      accept;

   assign accept     = start && !busy_ff;
   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = accept ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.sel      = dq_pkg::SEL_ZERO;
      cmd.status   = dq_pkg::ST_OK;
      cmd.capture  = accept;
      cmd.commit   = (state_ff == S_EXEC);
      if (state_ff == S_EXEC) begin
         if (stat.is_push) begin
            if (stat.full) begin
               cmd.status = dq_pkg::ST_FULL;
            end else begin
               cmd.write_en = 1'b1;
               cmd.advance  = 1'b1;
            end
         end else if (stat.is_read) begin
            if (stat.empty) begin
               cmd.status = dq_pkg::ST_EMPTY;
               cmd.sel    = dq_pkg::SEL_EMPTY;
            end else begin
               cmd.read_en = 1'b1;
               cmd.advance = 1'b1;
               cmd.sel     = dq_pkg::SEL_READ;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in == S_EXEC);
         strobe_ff <= (state_in == S_RESP);
      end
   end

   `ASSERT_IMPLIES(a_strobe_not_busy, clock, reset, strobe_ff, !busy_ff)
   `ASSERT_NEXT(a_accept_then_busy, clock, reset, start && !busy_ff, busy_ff)
   `ASSERT_NEXT(a_busy_then_strobe, clock, reset, busy_ff, strobe_ff && !busy_ff)

endmodule

`default_nettype wire

### rtl/core/dq_datapath.sv
// storage, pointers and result registers of the double-ended queue
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dq_datapath #(
   parameter  int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter  int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT,
   localparam int CW         = $clog2(DEPTH + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dq_pkg::dq_cmd_type                  cmd,
   output dq_pkg::dq_stat_type                      stat,
   input  wire logic [dq_pkg::OP_WIDTH-1:0]         req_operation,
   input  wire logic signed [dq_pkg::VALUE_WIDTH-1:0] req_push_value,
   output logic signed [dq_pkg::VALUE_WIDTH-1:0]    rsp_out_value,
   output logic [dq_pkg::STATUS_WIDTH-1:0]          rsp_status,
   output logic [CW-1:0]                            rsp_entry_count
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EXT_W = (DATA_WIDTH > dq_pkg::VALUE_WIDTH) ? DATA_WIDTH
                                                            : dq_pkg::VALUE_WIDTH;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [dq_pkg::OP_WIDTH-1:0]    op_ff;
   logic [dq_pkg::VALUE_WIDTH-1:0] value_ff;
   logic [AW-1:0]                  head_ff;
   logic [AW-1:0]                  tail_ff;
   logic [CW-1:0]                  count_ff;
   logic [DATA_WIDTH-1:0]          rd_ff;
   dq_pkg::result_sel_type         sel_ff;
   dq_pkg::status_type             status_ff;

   logic [AW-1:0]             head_prev;
   logic [AW-1:0]             head_next;
   logic [AW-1:0]             tail_prev;
   logic [AW-1:0]             tail_next;
   logic [AW-1:0]             addr;
   logic [DATA_WIDTH-1:0]     wdata;
   logic signed [EXT_W-1:0]   rd_ext;

   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? AW'(DEPTH - 1) : tail_ff - 1'b1;
   assign tail_next = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      stat.is_push = op_ff inside {dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK};
      stat.is_read = op_ff inside {dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
                                   dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK};
      stat.empty   = (count_ff == '0);
      stat.full    = (count_ff == CW'(DEPTH));
   end

   always_comb begin
      case (dq_pkg::op_type'(op_ff))
         dq_pkg::OP_PUSH_FRONT: addr = head_prev;
         dq_pkg::OP_PUSH_BACK:  addr = tail_ff;
         dq_pkg::OP_POP_FRONT:  addr = head_ff;
         dq_pkg::OP_PEEK_FRONT: addr = head_ff;
         dq_pkg::OP_POP_BACK:   addr = tail_prev;
         dq_pkg::OP_PEEK_BACK:  addr = tail_prev;
         default:               addr = head_ff;
      endcase
   end

   assign wdata = DATA_WIDTH'(EXT_W'(value_ff));

   // single-port store, registered read
   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         mem[addr] <= wdata;
      end
      if (cmd.read_en) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         value_ff <= req_push_value;
      end
      if (cmd.commit) begin
         sel_ff    <= cmd.sel;
         status_ff <= cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.advance) begin
         case (dq_pkg::op_type'(op_ff))
            dq_pkg::OP_PUSH_FRONT: begin
               head_ff  <= head_prev;
               count_ff <= count_ff + 1'b1;
            end
            dq_pkg::OP_PUSH_BACK: begin
               tail_ff  <= tail_next;
               count_ff <= count_ff + 1'b1;
            end
            dq_pkg::OP_POP_FRONT: begin
               head_ff  <= head_next;
               count_ff <= count_ff - 1'b1;
            end
            dq_pkg::OP_POP_BACK: begin
               tail_ff  <= tail_prev;
               count_ff <= count_ff - 1'b1;
            end
            default: begin
               head_ff <= head_ff;
            end
         endcase
      end
   end

   assign rd_ext = EXT_W'($signed(rd_ff));

   always_comb begin
      case (sel_ff)
         dq_pkg::SEL_READ:  rsp_out_value = rd_ext[dq_pkg::VALUE_WIDTH-1:0];
         dq_pkg::SEL_EMPTY: rsp_out_value = dq_pkg::EMPTY_VALUE;
         default:           rsp_out_value = '0;
      endcase
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;

   `ASSERT_IMPLIES(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `ASSERT_IMPLIES(a_no_write_when_full, clock, reset, cmd.write_en, !stat.full)
   `ASSERT_IMPLIES(a_no_read_when_empty, clock, reset, cmd.read_en, !stat.empty)

endmodule

`default_nettype wire
